[rtl/circular_next_free_slot_allocator_core_defines.svh]
// assertion macros for the slot allocator checker
// expects signals named clock and reset in the scope of use
`ifndef CIRCULAR_NEXT_FREE_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define CIRCULAR_NEXT_FREE_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define CNFSA_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("slot allocator check failed");

// next-cycle implication
`define CNFSA_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("slot allocator check failed");

`endif

[rtl/cnfsa_pkg.sv]
// shared types and constants for the circular slot allocator
// no dependencies
package cnfsa_pkg;

   localparam int SLOT_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int CSR_W       = 9;
   localparam int SCAN_W      = 10;
   localparam int GRANT_LIMIT = 256;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CSR_W-1:0] RING_RESET = CSR_W'(256);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

endpackage

[rtl/circular_next_free_slot_allocator_core.sv]
// circular next-free slot allocator: occupancy map with word-serial scan
// depends on cnfsa_pkg
//
// channel   dir  payload
// req       in   tdata[7:0] wanted_slot
// rsp       out  tdata[7:0] granted_slot, tuser[1:0] status
// csr       in   wdata[8:0] ring_size
//
// one map word is checked per cycle by a single free-bit search unit
// an invalid slot goes straight from idle to the response; a valid one is scanned from its word
// up to the ring top, then from word 0 up to the wanted slot, and any rsp stall adds to each item
// synchronous reset clears the map, ring size returns to 256
// req_tready is low from accept until the result transfer completes
module circular_next_free_slot_allocator_core
   import cnfsa_pkg::*;
#(
   parameter int SLOTS         = 256,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SLOT_W-1:0]     req_tdata,   // [7:0] wanted_slot
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] granted_slot
   output logic [STATUS_W-1:0]   rsp_tuser,   // [1:0] status
   input  logic                  csr_wen,
   input  logic [CSR_W-1:0]      csr_wdata    // [8:0] ring_size
);

   localparam int USED      = (SLOTS < GRANT_LIMIT) ? SLOTS : GRANT_LIMIT;
   localparam int MAP_WORDS = (USED + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW        = (MAP_WORD_BITS > 1) ? $clog2(MAP_WORD_BITS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_UP,
      ST_SCAN_WRAP,
      ST_RESP
   } state_type;

   state_type                                  state_ff;
   logic [MAP_WORDS-1:0][MAP_WORD_BITS-1:0]    map_ff;
   logic [CSR_W-1:0]                           ring_ff;
   logic [SLOT_W-1:0]                          want_ff;
   logic [WW-1:0]                              word_ff;
   logic [SCAN_W-1:0]                          base_ff;
   logic                                       rsp_valid_ff;
   logic [SLOT_W-1:0]                          grant_ff;
   status_type                                 status_ff;

   logic [CSR_W-1:0]         eff_ring;
   logic [MAP_WORD_BITS-1:0] cur_word;
   logic [MAP_WORD_BITS-1:0] cand;
   logic                     found;
   logic [BW-1:0]            hit_bit;
   logic [SCAN_W-1:0]        next_base;
   logic [WW-1:0]            start_word;
   logic [SCAN_W-1:0]        start_base;
   logic [SCAN_W-1:0]        hit_slot;

   assign eff_ring = (ring_ff > CSR_W'(USED)) ? CSR_W'(USED) : ring_ff;
   assign cur_word = map_ff[word_ff];
   assign next_base = base_ff + SCAN_W'(MAP_WORD_BITS);
   assign hit_slot = base_ff + SCAN_W'(hit_bit);

   // free candidates in the current word, bounded by ring and scan phase
   always_comb begin
      logic [SCAN_W-1:0] slot;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         slot = base_ff + SCAN_W'(j);
         cand[j] = !cur_word[j] && (slot < SCAN_W'(eff_ring)) &&
                   ((state_ff == ST_SCAN_WRAP) || (slot >= SCAN_W'(want_ff)));
      end
   end

   // lowest free candidate
   always_comb begin
      found   = 1'b0;
      hit_bit = '0;
      for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
         if (cand[j]) begin
            found   = 1'b1;
            hit_bit = BW'(j);
         end
      end
   end

   // word holding the wanted slot
   always_comb begin
      start_word = '0;
      start_base = '0;
      for (int k = 1; k < MAP_WORDS; k++) begin
         if (SCAN_W'(req_tdata) >= SCAN_W'(k * MAP_WORD_BITS)) begin
            start_word = WW'(k);
            start_base = SCAN_W'(k * MAP_WORD_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_ff       <= '0;
         ring_ff      <= RING_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            ring_ff <= csr_wdata;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  want_ff <= req_tdata;
                  word_ff <= start_word;
                  base_ff <= start_base;
                  if (CSR_W'(req_tdata) >= eff_ring) begin
                     grant_ff     <= '0;
                     status_ff    <= STATUS_INVALID;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RESP;
                  end else begin
                     state_ff <= ST_SCAN_UP;
                  end
               end
            end
            ST_SCAN_UP, ST_SCAN_WRAP: begin
               if (found) begin
                  map_ff[word_ff][hit_bit] <= 1'b1;
                  grant_ff     <= SLOT_W'(hit_slot);
                  status_ff    <= STATUS_GRANTED;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_RESP;
               end else if (state_ff == ST_SCAN_UP) begin
                  if (next_base >= SCAN_W'(eff_ring)) begin
                     word_ff  <= '0;
                     base_ff  <= '0;
                     state_ff <= ST_SCAN_WRAP;
                  end else begin
                     word_ff <= word_ff + WW'(1);
                     base_ff <= next_base;
                  end
               end else begin
                  if (next_base > SCAN_W'(want_ff)) begin
                     grant_ff     <= '0;
                     status_ff    <= STATUS_FULL;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RESP;
                  end else begin
                     word_ff <= word_ff + WW'(1);
                     base_ff <= next_base;
                  end
               end
            end
            ST_RESP: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = grant_ff;
   assign rsp_tuser  = status_ff;

endmodule

[rtl/cnfsa_checker.sv]
// port-level checks for the circular slot allocator, bound to the allocator core
// depends on cnfsa_pkg and circular_next_free_slot_allocator_core_defines.svh
`include "circular_next_free_slot_allocator_core_defines.svh"

module cnfsa_checker
   import cnfsa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   // status is one of the three codes
   `CNFSA_ASSERT_NOW(a_status_code, rsp_tvalid, rsp_tuser <= STATUS_INVALID)

   // failed requests carry a zero slot
   `CNFSA_ASSERT_NOW(a_fail_zero, rsp_tvalid && rsp_tuser != STATUS_GRANTED, rsp_tdata == '0)

   // one item in flight: no new request while a result is pending
   `CNFSA_ASSERT_NOW(a_one_in_flight, rsp_tvalid, !req_tready)

   // stalled result holds
   `CNFSA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind circular_next_free_slot_allocator_core cnfsa_checker u_cnfsa_checker (.*);

[tb/slot_grant_checker.sv]
// checker for the circular slot allocator: watches the req, rsp and csr transfers,
// keeps its own occupancy map and ring size, and compares each grant in order
// depends on cnfsa_pkg
module slot_grant_checker
   import cnfsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [SLOT_W-1:0]     req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]   rsp_tuser,
   input  logic                  csr_wen,
   input  logic [CSR_W-1:0]      csr_wdata,
   output int                    pending,
   output int                    mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } grant_type;

   logic             slot_busy [GRANT_LIMIT];
   logic [CSR_W-1:0] ring_size_now;
   grant_type        grants_due [$];

   function automatic grant_type allocate_slot(input logic [SLOT_W-1:0] wanted);
      int span;
      int probe;
      grant_type g;
      span = (int'(ring_size_now) > GRANT_LIMIT) ? GRANT_LIMIT : int'(ring_size_now);
      g.slot = '0;
      g.status = STATUS_INVALID;
      if (int'(wanted) >= span) return g;
      g.status = STATUS_FULL;
      probe = int'(wanted);
      for (int i = 0; i < span; i++) begin
         if (!slot_busy[probe]) begin
            slot_busy[probe] = 1'b1;
            g.slot = SLOT_W'(probe);
            g.status = STATUS_GRANTED;
            return g;
         end
         probe = (probe + 1 == span) ? 0 : probe + 1;
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type due;
      if (reset) begin
         foreach (slot_busy[i]) slot_busy[i] = 1'b0;
         ring_size_now = RING_RESET;
         grants_due.delete();
      end else begin
         if (csr_wen) ring_size_now = csr_wdata;
         if (req_tvalid && req_tready) grants_due = {grants_due, allocate_slot(req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            if (grants_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected rsp transfer, expected none, actual data %h status %0d",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               due = grants_due.pop_front();
               if (rsp_tdata !== RSP_DATA_W'(due.slot)) begin
                  mismatches++;
                  $display("%0t: granted slot mismatch, expected %h actual %h",
                           $time, RSP_DATA_W'(due.slot), rsp_tdata);
               end
               if (rsp_tuser !== due.status) begin
                  mismatches++;
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, due.status, rsp_tuser);
               end
            end
         end
      end
      pending = grants_due.size();
   end

endmodule

[tb/tb_top.sv]
// testbench top for circular_next_free_slot_allocator_core: clock, reset, stimulus and verdict
// depends on cnfsa_pkg, the allocator core and slot_grant_checker
module tb_top
   import cnfsa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 600;
   localparam int CALM_ITEMS     = 80;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SLOT_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_wen    = 1'b0;
   logic [CSR_W-1:0]      csr_wdata  = RING_RESET;

   int pending;
   int mismatches;
   int quiet_cycles = 0;
   int gap_mode     = 0;
   int stall_mode   = 0;
   int hold_request = 0;
   bit calm         = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   circular_next_free_slot_allocator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   slot_grant_checker grant_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .mismatches (mismatches)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : rsp_side
      int holds_done;
      holds_done = 0;
      @(posedge clock);
      forever begin
         if (hold_request != holds_done) begin
            holds_done = hold_request;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) < stall_mode) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic offer_slot(input logic [SLOT_W-1:0] wanted);
      if (!calm && $urandom_range(0, 3) < gap_mode) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tdata  <= wanted;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // ring size only changes once every grant has come back
   task automatic write_ring(input logic [CSR_W-1:0] value);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
      csr_wdata <= value;
      csr_wen   <= 1'b1;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   initial begin : stimulus
      int sent;
      int span;
      int pick;
      int phase_items;
      logic [CSR_W-1:0] ring_value;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default ring: free slot, top slot, probing and wrap past the top
      offer_slot(SLOT_W'(0));
      offer_slot(SLOT_W'(255));
      offer_slot(SLOT_W'(0));
      offer_slot(SLOT_W'(255));
      offer_slot(SLOT_W'(128));
      offer_slot(SLOT_W'(170));
      offer_slot(SLOT_W'(85));
      // single slot ring already taken, and slots outside it
      write_ring(CSR_W'(1));
      offer_slot(SLOT_W'(0));
      offer_slot(SLOT_W'(1));
      offer_slot(SLOT_W'(255));
      // empty ring
      write_ring(CSR_W'(0));
      offer_slot(SLOT_W'(0));
      // oversized ring saturates
      write_ring(CSR_W'(511));
      offer_slot(SLOT_W'(200));
      write_ring(CSR_W'(300));
      offer_slot(SLOT_W'(255));
      // shrunken ring that is full although slots above it are free
      write_ring(CSR_W'(4));
      offer_slot(SLOT_W'(3));
      offer_slot(SLOT_W'(2));
      write_ring(CSR_W'(6));
      offer_slot(SLOT_W'(5));
      offer_slot(SLOT_W'(5));
      offer_slot(SLOT_W'(0));

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 3);
         case (pick)
            0:       ring_value = CSR_W'($urandom_range(1, 16));
            1:       ring_value = CSR_W'($urandom_range(17, 128));
            2:       ring_value = CSR_W'($urandom_range(129, 256));
            default: ring_value = CSR_W'($urandom_range(0, 511));
         endcase
         write_ring(ring_value);
         calm       = (sent >= RANDOM_ITEMS - CALM_ITEMS);
         gap_mode   = $urandom_range(0, 2);
         stall_mode = $urandom_range(0, 2);
         if (sent == 0) hold_request++;
         span = (ring_value > GRANT_LIMIT) ? GRANT_LIMIT : int'(ring_value);
         phase_items = $urandom_range(20, 60);
         repeat (phase_items) begin
            pick = $urandom_range(0, 19);
            if (span == 0 || pick < 3) offer_slot(SLOT_W'($urandom_range(0, 255)));
            else if (pick == 3) offer_slot(SLOT_W'(span - 1));
            else if (pick == 4) offer_slot(SLOT_W'(0));
            else offer_slot(SLOT_W'($urandom_range(0, span - 1)));
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
